@@ rtl/sfc_pkg.sv @@
// Shared types and constants for the sphere frustum culling block.
package sfc_pkg;

    localparam int PLANE_COUNT = 6;

    typedef enum logic [1:0] {
        ACT_LOAD = 2'd0,
        ACT_TEST = 2'd1,
        ACT_MARK = 2'd2,
        ACT_NONE = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SQRT,
        ST_MUL,
        ST_CMP,
        ST_READ,
        ST_WAIT,
        ST_WRITE,
        ST_OUT
    } t_state;

endpackage

@@ rtl/sfc_sqrt.sv @@
// Iterative floor integer square root, one result bit per cycle.
module sfc_sqrt (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [38:0]         i_value,
    output logic                o_busy,
    output logic                o_done,
    output logic [19:0]         o_root
);
    // Radicand is value << 16, at most 55 bits, so 28 root steps run; the
    // largest value (2^23 Q16.16 << 16) gives a root under 2^20.
    logic [55:0] r_rem;
    logic [27:0] r_root;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [55:0] r_val;

    logic [29:0] trial;
    logic [29:0] rem_hi;
    logic [55:0] n_rem;
    logic [27:0] n_root;

    always_comb begin
        rem_hi = {r_rem[27:0], r_val[55:54]};
        trial  = {r_root, 2'b01};
        if (rem_hi >= trial) begin
            n_rem  = {26'd0, rem_hi - trial};
            n_root = {r_root[26:0], 1'b1};
        end else begin
            n_rem  = {26'd0, rem_hi};
            n_root = {r_root[26:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd27;
                r_rem  <= '0;
                r_root <= '0;
                r_val  <= {1'b0, i_value, 16'd0};
            end else if (r_busy) begin
                r_rem  <= n_rem;
                r_root <= n_root;
                r_val  <= {r_val[53:0], 2'b00};
                r_cnt  <= r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_root = r_root[19:0];
endmodule

@@ rtl/sfc_mac.sv @@
// Shared 32x32 multiplier with floor shift and wide accumulator.
module sfc_mac (
    input  logic               i_clk,
    input  logic               i_clear,
    input  logic               i_en,
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    input  logic               i_add_en,
    input  logic signed [31:0] i_add,
    output logic signed [50:0] o_acc
);
    logic signed [63:0] r_prod;
    logic               r_prod_v;
    logic signed [50:0] r_acc;
    logic signed [50:0] n_acc;

    // Arithmetic shift right floors, matching rounding toward minus infinity.
    always_comb begin
        n_acc = r_acc;
        if (r_prod_v) n_acc = n_acc + 51'(r_prod >>> 16);
        if (i_add_en) n_acc = n_acc + 51'(i_add);
    end

    always_ff @(posedge i_clk) begin
        r_prod   <= 64'(i_a) * 64'(i_b);
        r_prod_v <= i_en;
        if (i_clear) r_acc <= '0;
        else         r_acc <= n_acc;
    end

    assign o_acc = r_acc;
endmodule

@@ rtl/sphere_frustum_cull_with_history.sv @@
// Sphere frustum culling of splats with a per-splat visibility history.
// A test word's verdict follows the square root, six planes on one shared multiplier, and
// the history read, wait and write states; a mark's verdict follows only those history states.
// Only one word is in work; the next is accepted once a test's or a mark's verdict has left
// the output, which a stall on the verdict delays; a load or an unused action keeps it idle.
// Reset clears all HISTORY_DEPTH history entries one entry per cycle, input stalled.
module sphere_frustum_cull_with_history #(
    parameter int HISTORY_DEPTH   = 16384,
    parameter int COHERENT_FRAMES = 3
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_action,
    input  logic [2:0]         i_plane_index,
    input  logic signed [31:0] i_vec_x,
    input  logic signed [31:0] i_vec_y,
    input  logic signed [31:0] i_vec_z,
    input  logic signed [31:0] i_plane_offset,
    input  logic [13:0]        i_splat_index,
    input  logic signed [15:0] i_cov_xx,
    input  logic signed [15:0] i_cov_yy,
    input  logic signed [15:0] i_cov_zz,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [13:0]        o_result_index,
    output logic               o_visible,
    output logic               o_kept_by_history,
    output logic [7:0]         o_history_after
);
    localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam logic [7:0] COH_MASK = 8'((9'd1 << COHERENT_FRAMES) - 9'd1);

    // Plane storage: six small register rows, each read at one index.
    logic signed [31:0] r_nx [sfc_pkg::PLANE_COUNT];
    logic signed [31:0] r_ny [sfc_pkg::PLANE_COUNT];
    logic signed [31:0] r_nz [sfc_pkg::PLANE_COUNT];
    logic signed [31:0] r_pd [sfc_pkg::PLANE_COUNT];

    // History memory, cleared by a sweep after reset.
    logic [7:0] r_hist_mem [HISTORY_DEPTH];
    logic [7:0] r_hist_rd;
    logic [AW:0] r_clr_addr;

    sfc_pkg::t_state r_state, n_state;
    sfc_pkg::t_action r_act;
    logic [13:0] r_sidx;
    logic signed [31:0] r_px, r_py, r_pz;
    logic [21:0] r_radius;         // 3 * root, Q16.16
    logic [2:0]  r_plane;
    logic [1:0]  r_axis;
    logic [2:0]  r_mcnt;           // multiplier issue/drain counter
    logic        r_inside;
    logic        r_vis, r_kept;
    logic [7:0]  r_hist_new;
    logic        r_out_v;
    logic [13:0] r_o_idx;
    logic        r_o_vis, r_o_kept;
    logic [7:0]  r_o_hist;

    logic accept, in_store;
    logic [AW-1:0] hist_addr;
    logic signed [15:0] m1, m2;
    logic        sq_start, sq_busy, sq_done;
    logic [19:0] root;
    logic        mac_clear, mac_en, mac_add_en;
    logic signed [31:0] mac_a, mac_b;
    logic signed [50:0] acc;

    // Indexes beyond the store read as zero and are never written.
    assign in_store  = 32'(r_sidx) < HISTORY_DEPTH;
    assign hist_addr = AW'(r_sidx);
    assign accept = i_valid && !o_stall;

    always_comb begin
        m1 = (i_cov_yy > i_cov_xx) ? i_cov_yy : i_cov_xx;
        m2 = (i_cov_zz > m1) ? i_cov_zz : m1;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            sfc_pkg::ST_CLEAR: if (r_clr_addr == (AW+1)'(HISTORY_DEPTH - 1))
                n_state = sfc_pkg::ST_IDLE;
            sfc_pkg::ST_IDLE: if (accept) begin
                case (sfc_pkg::t_action'(i_action))
                    sfc_pkg::ACT_TEST: n_state = sfc_pkg::ST_SQRT;
                    sfc_pkg::ACT_MARK: n_state = sfc_pkg::ST_READ;
                    default:           n_state = sfc_pkg::ST_IDLE;
                endcase
            end
            sfc_pkg::ST_SQRT:  if (sq_done) n_state = sfc_pkg::ST_MUL;
            sfc_pkg::ST_MUL:   if (r_mcnt == 3'd4) n_state = sfc_pkg::ST_CMP;
            sfc_pkg::ST_CMP:   n_state = (r_plane == 3'(sfc_pkg::PLANE_COUNT - 1))
                                         ? sfc_pkg::ST_READ : sfc_pkg::ST_MUL;
            sfc_pkg::ST_READ:  n_state = sfc_pkg::ST_WAIT;
            sfc_pkg::ST_WAIT:  n_state = sfc_pkg::ST_WRITE;
            sfc_pkg::ST_WRITE: n_state = sfc_pkg::ST_OUT;
            sfc_pkg::ST_OUT:   if (!r_out_v) n_state = sfc_pkg::ST_IDLE;
            default:           n_state = sfc_pkg::ST_IDLE;
        endcase
    end

    // Control outputs.
    always_comb begin
        o_stall    = (r_state != sfc_pkg::ST_IDLE);
        sq_start   = accept && (sfc_pkg::t_action'(i_action) == sfc_pkg::ACT_TEST);
        mac_clear  = (r_state == sfc_pkg::ST_SQRT) || (r_state == sfc_pkg::ST_CMP);
        mac_en     = (r_state == sfc_pkg::ST_MUL) && (r_mcnt < 3'd3);
        mac_add_en = (r_state == sfc_pkg::ST_MUL) && (r_mcnt == 3'd0);
        case (r_axis)
            2'd0:    begin mac_a = r_px; mac_b = r_nx[r_plane]; end
            2'd1:    begin mac_a = r_py; mac_b = r_ny[r_plane]; end
            default: begin mac_a = r_pz; mac_b = r_nz[r_plane]; end
        endcase
    end

    sfc_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(sq_start),
        .i_value({16'd0, m2[15] ? 23'd0 : {m2[14:0], 8'd0}}),
        .o_busy (sq_busy),
        .o_done (sq_done),
        .o_root (root)
    );

    sfc_mac u_mac (
        .i_clk   (i_clk),
        .i_clear (mac_clear),
        .i_en    (mac_en),
        .i_a     (mac_a),
        .i_b     (mac_b),
        .i_add_en(mac_add_en),
        .i_add   (r_pd[r_plane]),
        .o_acc   (acc)
    );

    // History memory port.
    always_ff @(posedge i_clk) begin
        if (r_state == sfc_pkg::ST_CLEAR)
            r_hist_mem[r_clr_addr[AW-1:0]] <= 8'd0;
        else if (r_state == sfc_pkg::ST_WRITE && in_store)
            r_hist_mem[hist_addr] <= r_hist_new;
        r_hist_rd <= r_hist_mem[hist_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= sfc_pkg::ST_CLEAR;
            r_clr_addr <= '0;
            r_out_v    <= 1'b0;
            for (int i = 0; i < sfc_pkg::PLANE_COUNT; i++) begin
                r_nx[i] <= '0; r_ny[i] <= '0; r_nz[i] <= '0; r_pd[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_state == sfc_pkg::ST_CLEAR) r_clr_addr <= r_clr_addr + (AW+1)'(1);
            if (r_out_v && !i_stall) r_out_v <= 1'b0;
            if (accept) begin
                r_act  <= sfc_pkg::t_action'(i_action);
                r_sidx <= i_splat_index;
                r_px <= i_vec_x; r_py <= i_vec_y; r_pz <= i_vec_z;
                r_inside <= 1'b1;
                if (sfc_pkg::t_action'(i_action) == sfc_pkg::ACT_LOAD &&
                    i_plane_index < 3'(sfc_pkg::PLANE_COUNT)) begin
                    r_nx[i_plane_index] <= i_vec_x;
                    r_ny[i_plane_index] <= i_vec_y;
                    r_nz[i_plane_index] <= i_vec_z;
                    r_pd[i_plane_index] <= i_plane_offset;
                end
            end
            if (r_state == sfc_pkg::ST_SQRT) begin
                r_radius <= 22'(root) * 22'd3;
                r_plane  <= '0;
                r_axis   <= '0;
                r_mcnt   <= '0;
            end
            if (r_state == sfc_pkg::ST_MUL) begin
                r_mcnt <= r_mcnt + 3'd1;
                if (r_axis != 2'd2 && r_mcnt < 3'd2) r_axis <= r_axis + 2'd1;
            end
            if (r_state == sfc_pkg::ST_CMP) begin
                if (acc < -$signed({29'd0, r_radius})) r_inside <= 1'b0;
                r_plane <= r_plane + 3'd1;
                r_axis  <= '0;
                r_mcnt  <= '0;
            end
            if (r_state == sfc_pkg::ST_WAIT) begin
                logic v, k;
                logic [7:0] h;
                h = in_store ? r_hist_rd : 8'd0;
                v = (r_act == sfc_pkg::ACT_TEST) && r_inside;
                k = (r_act == sfc_pkg::ACT_TEST) && !r_inside &&
                    ((h & COH_MASK) == COH_MASK);
                r_vis  <= v || k;
                r_kept <= k;
                r_hist_new <= {h[6:0], v || k};
            end
            if (r_state == sfc_pkg::ST_WRITE) begin
                r_out_v   <= 1'b1;
                r_o_idx   <= r_sidx;
                r_o_vis   <= r_vis;
                r_o_kept  <= r_kept;
                r_o_hist  <= in_store ? r_hist_new : 8'd0;
            end
        end
    end

    assign o_valid           = r_out_v;
    assign o_result_index    = r_o_idx;
    assign o_visible         = r_o_vis;
    assign o_kept_by_history = r_o_kept;
    assign o_history_after   = r_o_hist;

    // A kept verdict is always a visible one.
    a_kept_vis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kept_by_history |-> o_visible)
        else $error("kept without visible");
    // Nothing is accepted while a result is still pending.
    a_no_accept_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("accept while result pending");
    // The square root unit only runs during the test sequence.
    a_sqrt_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sq_busy |-> r_state == sfc_pkg::ST_SQRT)
        else $error("sqrt busy outside test");
endmodule
